>>> src/abkf_pkg.sv
// package for the angle/bias kalman filter: widths, reset values, register indexes,
// controller commands and the datapath status struct
// no dependencies
`timescale 1ns / 1ps
package abkf_pkg;
	localparam int DataW = 32;
	localparam int NoiseW = 31;
	localparam int DtW = 24;
	localparam int FracW = 24;
	localparam int CfgIdxW = 2;
	localparam int DivW = 32;
	localparam int DivIterW = 6;

	localparam logic [NoiseW-1:0] QaReset = 31'd16777;
	localparam logic [NoiseW-1:0] QbReset = 31'd168;
	localparam logic [NoiseW-1:0] RmReset = 31'd16777216;
	localparam logic signed [DataW-1:0] OneQ24 = 32'sd16777216;

	localparam logic [CfgIdxW-1:0] REG_QA = 2'd0;
	localparam logic [CfgIdxW-1:0] REG_QB = 2'd1;
	localparam logic [CfgIdxW-1:0] REG_RM = 2'd2;

	// datapath operations selected by the controller at each step
	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_RATE,
		OP_ANGLE,
		OP_T,
		OP_P00,
		OP_P11,
		OP_S,
		OP_DIV0,
		OP_DIV1,
		OP_Y0,
		OP_Y1,
		OP_CANG,
		OP_CBIAS,
		OP_C00,
		OP_C01,
		OP_C10,
		OP_C11
	} op_t;

	typedef struct packed {
		op_t  op;
		logic div_start;
		logic mul_start;
	} dp_cmd_t;

	typedef struct packed {
		logic mul_done;
		logic div_done;
	} dp_status_t;

	function automatic logic signed [DataW-1:0] sat32(input logic signed [65:0] v);
		if (v > 66'sd2147483647)
			return 32'sh7fffffff;
		else if (v < -66'sd2147483648)
			return 32'sh80000000;
		else
			return v[DataW-1:0];
	endfunction
endpackage

>>> src/abkf_if.sv
// valid/ready channel interfaces for items, results and configuration writes
// depends on abkf_pkg
`timescale 1ns / 1ps
interface abkf_in_if import abkf_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DataW-1:0] rate_sample;
	logic signed [DataW-1:0] angle_sample;
	logic [DtW-1:0] time_step;
	modport source (output valid, rate_sample, angle_sample, time_step, input ready);
	modport sink (input valid, rate_sample, angle_sample, time_step, output ready);
endinterface

interface abkf_out_if import abkf_pkg::*; ();
	logic valid;
	logic ready;
	logic signed [DataW-1:0] angle_estimate;
	logic signed [DataW-1:0] bias_estimate;
	modport source (output valid, angle_estimate, bias_estimate, input ready);
	modport sink (input valid, angle_estimate, bias_estimate, output ready);
endinterface

interface abkf_cfg_if import abkf_pkg::*; ();
	logic valid;
	logic ready;
	logic [CfgIdxW-1:0] index;
	logic [DataW-1:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> src/abkf_div.sv
// restoring divider: floor-free signed quotient num*2^24 / den, truncated toward zero,
// saturated to 32 bit; one quotient bit per cycle. depends on abkf_pkg
`timescale 1ns / 1ps
module abkf_div import abkf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic signed [DataW-1:0] num,
	input  logic [DataW:0] den,
	output logic done,
	output logic signed [DataW-1:0] quo
);
	localparam int NW = DataW + FracW;
	localparam int QW = NW;

	logic busy_q;
	logic [DivIterW:0] cnt_q;
	logic [NW-1:0] dvd_q;
	logic [DataW+1:0] rem_q;
	logic [DataW:0] den_q;
	logic neg_q;
	logic [DataW+1:0] trial;
	logic [NW:0] mag;
	logic signed [65:0] sq;

	assign trial = {rem_q[DataW:0], dvd_q[NW-1]} - {1'b0, den_q};
	assign mag = {1'b0, dvd_q};
	assign sq = neg_q ? -$signed({9'd0, mag}) : $signed({9'd0, mag});

	// shift-subtract loop over the 56 dividend bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= (DivIterW+1)'(NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == (DivIterW+1)'(1)) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {(num[DataW-1] ? 32'(-num) : 32'(num)), {FracW{1'b0}}};
			rem_q <= '0;
			den_q <= den;
			neg_q <= num[DataW-1];
		end else if (busy_q) begin
			if (!trial[DataW+1]) begin
				rem_q <= trial;
				dvd_q <= {dvd_q[NW-2:0], 1'b1};
			end else begin
				rem_q <= {rem_q[DataW:0], dvd_q[NW-1]};
				dvd_q <= {dvd_q[NW-2:0], 1'b0};
			end
		end
	end

	assign quo = sat32(sq);
endmodule

>>> src/abkf_datapath.sv
// datapath: state and covariance registers, one shared 35x35 multiplier (registered),
// the divider and the saturating adders. depends on abkf_pkg, abkf_div
`timescale 1ns / 1ps
module abkf_datapath import abkf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	output dp_status_t status,
	input  logic signed [DataW-1:0] rate_in,
	input  logic signed [DataW-1:0] meas_in,
	input  logic [DtW-1:0] dt_in,
	input  logic [NoiseW-1:0] qa,
	input  logic [NoiseW-1:0] qb,
	input  logic [NoiseW-1:0] rm,
	output logic signed [DataW-1:0] angle_out,
	output logic signed [DataW-1:0] bias_out
);
	logic signed [DataW-1:0] ang_q, bias_q, c00_q, c01_q, c10_q, c11_q;
	logic signed [DataW-1:0] meas_q, rate_q, t_q, p00_q, p01_q, p10_q, p11_q;
	logic signed [DataW-1:0] k0_q, k1_q, y_q;
	logic [DtW-1:0] dt_q;
	logic signed [DataW+1:0] s_q;
	logic spos_q;

	// multiplier operand selection by step
	logic signed [DataW+2:0] ma, mb;
	logic signed [DataW+2:0] ma_q, mb_q;
	logic signed [69:0] prod_q;
	logic mst_q;
	logic mul_done_q;
	logic div_done;
	logic signed [45:0] mres;
	logic signed [DataW+2:0] dsum;
	logic signed [DataW-1:0] div_q;

	assign status = '{mul_done: mul_done_q, div_done: div_done};

	// t - c01 - c10 + qa can reach 2^33 - 2, kept at multiplier operand width
	assign dsum = 35'(t_q) - 35'(c01_q) - 35'(c10_q) + $signed({4'b0, qa});

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (cmd.op)
			OP_RATE:  begin ma = $signed({11'd0, dt_q}); mb = 35'(rate_q); end
			OP_T:     begin ma = $signed({11'd0, dt_q}); mb = 35'(c11_q); end
			OP_P00:   begin ma = $signed({11'd0, dt_q}); mb = dsum; end
			OP_P11:   begin ma = $signed({4'd0, qb}); mb = $signed({11'd0, dt_q}); end
			OP_Y0:    begin ma = 35'(k0_q); mb = 35'(y_q); end
			OP_Y1:    begin ma = 35'(k1_q); mb = 35'(y_q); end
			OP_C00:   begin ma = 35'(k0_q); mb = 35'(p00_q); end
			OP_C01:   begin ma = 35'(k0_q); mb = 35'(p01_q); end
			OP_C10:   begin ma = 35'(k1_q); mb = 35'(p00_q); end
			OP_C11:   begin ma = 35'(k1_q); mb = 35'(p01_q); end
			default:  begin ma = '0; mb = '0; end
		endcase
	end

	// operands registered, then product registered
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mst_q <= 1'b0;
			mul_done_q <= 1'b0;
		end else begin
			mst_q <= cmd.mul_start;
			mul_done_q <= mst_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_start) begin
			ma_q <= ma;
			mb_q <= mb;
		end
		prod_q <= ma_q * mb_q;
	end

	assign mres = prod_q[69:FracW];

	abkf_div u_div (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num(cmd.op == OP_DIV1 ? p10_q : p00_q),
		.den(s_q[DataW:0]), .done(div_done), .quo(div_q)
	);

	// state update per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ang_q <= '0;
			bias_q <= '0;
			c00_q <= OneQ24;
			c01_q <= '0;
			c10_q <= '0;
			c11_q <= OneQ24;
		end else begin
			unique case (cmd.op)
				OP_ANGLE: ang_q <= sat32(66'(ang_q) + 66'(mres));
				OP_CANG:  ang_q <= sat32(66'(ang_q) + 66'(mres));
				OP_CBIAS: bias_q <= sat32(66'(bias_q) + 66'(mres));
				OP_C00:   c00_q <= sat32(66'(p00_q) - 66'(mres));
				OP_C01:   c01_q <= sat32(66'(p01_q) - 66'(mres));
				OP_C10:   c10_q <= sat32(66'(p10_q) - 66'(mres));
				OP_C11:   c11_q <= sat32(66'(p11_q) - 66'(mres));
				default:  ;
			endcase
		end
	end

	// working registers
	always_ff @(posedge clk) begin
		unique case (cmd.op)
			OP_LOAD: begin
				rate_q <= rate_in;
				meas_q <= meas_in;
				dt_q <= dt_in;
			end
			OP_RATE:   rate_q <= sat32(66'(rate_q) - 66'(bias_q));
			OP_T:      t_q <= mres[DataW-1:0];
			OP_P00: begin
				p00_q <= sat32(66'(c00_q) + 66'(mres));
				p01_q <= sat32(66'(c01_q) - 66'(t_q));
				p10_q <= sat32(66'(c10_q) - 66'(t_q));
			end
			OP_P11:    p11_q <= sat32(66'(c11_q) + 66'(mres));
			OP_S: begin
				s_q <= 34'(p00_q) + $signed({3'b0, rm});
				spos_q <= (34'(p00_q) + $signed({3'b0, rm})) > 34'sd0;
			end
			OP_DIV0: begin
				k0_q <= spos_q ? div_q : '0;
				y_q <= sat32(66'(meas_q) - 66'(ang_q));
			end
			OP_DIV1:   k1_q <= spos_q ? div_q : '0;
			default:   ;
		endcase
	end

	assign angle_out = ang_q;
	assign bias_out = bias_q;
endmodule

>>> src/abkf_ctrl.sv
// controller: sequences one filter step over the shared multiplier and divider,
// handles the input and output handshakes. depends on abkf_pkg
`timescale 1ns / 1ps
module abkf_ctrl import abkf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	output logic out_valid,
	input  logic out_ready,
	input  dp_status_t status,
	output dp_cmd_t cmd
);
	localparam logic [4:0] S_IDLE = 5'd0;
	localparam logic [4:0] S_RATE = 5'd1;
	localparam logic [4:0] S_MANG = 5'd2;
	localparam logic [4:0] S_MT = 5'd4;
	localparam logic [4:0] S_MP00 = 5'd5;
	localparam logic [4:0] S_MP11 = 5'd7;
	localparam logic [4:0] S_S = 5'd9;
	localparam logic [4:0] S_D0 = 5'd10;
	localparam logic [4:0] S_D1 = 5'd11;
	localparam logic [4:0] S_K1 = 5'd12;
	localparam logic [4:0] S_MB = 5'd14;
	localparam logic [4:0] S_M00 = 5'd15;
	localparam logic [4:0] S_M01 = 5'd16;
	localparam logic [4:0] S_M10 = 5'd17;
	localparam logic [4:0] S_M11 = 5'd18;
	localparam logic [4:0] S_OUT = 5'd19;

	logic [4:0] st_q, st_d;
	logic wait_q, wait_d;
	op_t iss_op, app_op;
	logic [4:0] mul_nxt;

	assign in_ready = (st_q == S_IDLE);
	assign out_valid = (st_q == S_OUT);

	// multiply steps: op to issue, op to apply with the product, following state
	always_comb begin
		iss_op = OP_NONE;
		app_op = OP_NONE;
		mul_nxt = S_IDLE;
		unique case (st_q)
			S_MANG:  begin iss_op = OP_RATE; app_op = OP_ANGLE; mul_nxt = S_MT; end
			S_MT:    begin iss_op = OP_T; app_op = OP_T; mul_nxt = S_MP00; end
			S_MP00:  begin iss_op = OP_P00; app_op = OP_P00; mul_nxt = S_MP11; end
			S_MP11:  begin iss_op = OP_P11; app_op = OP_P11; mul_nxt = S_S; end
			S_K1:    begin iss_op = OP_Y0; app_op = OP_CANG; mul_nxt = S_MB; end
			S_MB:    begin iss_op = OP_Y1; app_op = OP_CBIAS; mul_nxt = S_M00; end
			S_M00:   begin iss_op = OP_C00; app_op = OP_C00; mul_nxt = S_M01; end
			S_M01:   begin iss_op = OP_C01; app_op = OP_C01; mul_nxt = S_M10; end
			S_M10:   begin iss_op = OP_C10; app_op = OP_C10; mul_nxt = S_M11; end
			S_M11:   begin iss_op = OP_C11; app_op = OP_C11; mul_nxt = S_OUT; end
			default: begin iss_op = OP_NONE; app_op = OP_NONE; mul_nxt = S_IDLE; end
		endcase
	end

	// each multiply step: issue, wait for done, apply the op carried in that cycle
	always_comb begin
		st_d = st_q;
		wait_d = wait_q;
		cmd = '{op: OP_NONE, div_start: 1'b0, mul_start: 1'b0};
		unique case (st_q)
			S_IDLE: if (in_valid) begin cmd.op = OP_LOAD; st_d = S_RATE; end
			S_RATE: begin cmd.op = OP_RATE; st_d = S_MANG; end
			S_MANG, S_MT, S_MP00, S_MP11, S_K1, S_MB, S_M00, S_M01, S_M10, S_M11: begin
				if (!wait_q) begin
					cmd.op = iss_op; cmd.mul_start = 1'b1; wait_d = 1'b1;
				end else if (status.mul_done) begin
					cmd.op = app_op; wait_d = 1'b0; st_d = mul_nxt;
				end
			end
			S_S: begin cmd.op = OP_S; st_d = S_D0; end
			S_D0: if (!wait_q) begin
				cmd.op = OP_DIV0; cmd.div_start = 1'b1; wait_d = 1'b1;
			end else if (status.div_done) begin
				cmd.op = OP_DIV0; wait_d = 1'b0; st_d = S_D1;
			end
			S_D1: if (!wait_q) begin
				cmd.op = OP_DIV1; cmd.div_start = 1'b1; wait_d = 1'b1;
			end else if (status.div_done) begin
				cmd.op = OP_DIV1; wait_d = 1'b0; st_d = S_K1;
			end
			S_OUT: if (out_ready) st_d = S_IDLE;
			default: st_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			wait_q <= 1'b0;
		end else begin
			st_q <= st_d;
			wait_q <= wait_d;
		end
	end
endmodule

>>> src/angle_bias_kalman_filter.sv
// top level of the angle/bias kalman filter: config registers, controller and datapath
// depends on abkf_pkg, abkf_if, abkf_ctrl, abkf_datapath
`timescale 1ns / 1ps
// Two-state (angle, gyro bias) Kalman filter in fixed point. One transaction on
// in_ch (rate Q16.16, angle Q16.16, time step Q0.24) yields one transaction on
// out_ch with the corrected angle and bias. Items are handled one at a time: each
// item is accepted, then passes through single steps for the rate and the
// innovation variance, ten passes through the shared multiplier and two divider
// passes for the gains (56 quotient bits each), ending in the result step. While
// out_ch is held off the next item is not accepted. Configuration writes on cfg_ch
// (index 0 angle noise, 1 bias noise, 2 measurement noise) are always accepted and
// should only be made while the filter is idle.
module angle_bias_kalman_filter import abkf_pkg::*; (
	input logic clk,
	input logic arst_n,
	abkf_in_if.sink in_ch,
	abkf_out_if.source out_ch,
	abkf_cfg_if.sink cfg_ch
);
	logic [NoiseW-1:0] qa_q, qb_q, rm_q;
	dp_cmd_t cmd;
	dp_status_t status;

	// configuration registers
	assign cfg_ch.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qa_q <= QaReset;
			qb_q <= QbReset;
			rm_q <= RmReset;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				REG_QA:  qa_q <= cfg_ch.data[NoiseW-1:0];
				REG_QB:  qb_q <= cfg_ch.data[NoiseW-1:0];
				REG_RM:  rm_q <= cfg_ch.data[NoiseW-1:0];
				default: ;
			endcase
		end
	end

	abkf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.status(status), .cmd(cmd)
	);

	abkf_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .status(status),
		.rate_in(in_ch.rate_sample), .meas_in(in_ch.angle_sample), .dt_in(in_ch.time_step),
		.qa(qa_q), .qb(qb_q), .rm(rm_q),
		.angle_out(out_ch.angle_estimate), .bias_out(out_ch.bias_estimate)
	);
endmodule

>>> tb/tb.sv
// testbench for the angle/bias kalman filter: bit-exact fixed-point predictor,
// queue-fed driver, monitor with field checks, config phases and watchdog
// depends on abkf_pkg, abkf_if and the angle_bias_kalman_filter rtl
`timescale 1ns / 1ps
module tb;
	import abkf_pkg::*;

	// index past the last register, writes to it are dropped
	localparam logic [CfgIdxW-1:0] REG_NONE = 2'd3;

	typedef struct packed {
		logic signed [DataW-1:0] rate;
		logic signed [DataW-1:0] angle;
		logic [DtW-1:0] dt;
	} sample_t;

	typedef struct packed {
		logic signed [DataW-1:0] angle;
		logic signed [DataW-1:0] bias;
	} estimate_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	abkf_in_if in_ch ();
	abkf_out_if out_ch ();
	abkf_cfg_if cfg_ch ();

	angle_bias_kalman_filter dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// predictor state and shadow registers
	longint q_angle, q_bias, q_meas;
	longint f_angle, f_bias, c00, c01, c10, c11;

	sample_t pending_samples[$];
	estimate_t expected_estimates[$];
	int n_errors = 0;
	int n_checked = 0;
	int n_sent = 0;
	int n_added = 0;
	bit no_idle = 1'b0;
	int hold_cycles = 0;
	bit drain_wait = 1'b0;
	int quiet_cycles = 0;

	function automatic longint clamp32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// product rescaled by 24 bits, rounding toward minus infinity
	function automatic longint mul_q24(longint a, longint b);
		longint p;
		p = a * b;
		return p >>> FracW;
	endfunction

	function automatic void filter_reset();
		q_angle = QaReset;
		q_bias = QbReset;
		q_meas = RmReset;
		f_angle = 0;
		f_bias = 0;
		c00 = OneQ24;
		c01 = 0;
		c10 = 0;
		c11 = OneQ24;
	endfunction

	function automatic estimate_t filter_step(sample_t s);
		longint dt, rate, t, p00, p01, p10, p11, sv, k0, k1, y;
		estimate_t e;
		dt = longint'(s.dt);
		// predict
		rate = clamp32(longint'(s.rate) - f_bias);
		f_angle = clamp32(f_angle + mul_q24(dt, rate));
		t = mul_q24(dt, c11);
		p00 = clamp32(c00 + mul_q24(dt, t - c01 - c10 + q_angle));
		p01 = clamp32(c01 - t);
		p10 = clamp32(c10 - t);
		p11 = clamp32(c11 + mul_q24(q_bias, dt));
		// gains, zero when the innovation variance is not positive
		sv = p00 + q_meas;
		if (sv > 0) begin
			k0 = clamp32((p00 * longint'(OneQ24)) / sv);
			k1 = clamp32((p10 * longint'(OneQ24)) / sv);
		end else begin
			k0 = 0;
			k1 = 0;
		end
		// correct, covariance update from the predicted p00 and p01
		y = clamp32(longint'(s.angle) - f_angle);
		f_angle = clamp32(f_angle + mul_q24(k0, y));
		f_bias = clamp32(f_bias + mul_q24(k1, y));
		c00 = clamp32(p00 - mul_q24(k0, p00));
		c01 = clamp32(p01 - mul_q24(k0, p01));
		c10 = clamp32(p10 - mul_q24(k1, p00));
		c11 = clamp32(p11 - mul_q24(k1, p01));
		e.angle = f_angle[31:0];
		e.bias = f_bias[31:0];
		return e;
	endfunction

	// driver: offers queued samples with random idle bursts
	int send_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.rate_sample <= '0;
			in_ch.angle_sample <= '0;
			in_ch.time_step <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_estimates.push_back(filter_step(
					{in_ch.rate_sample, in_ch.angle_sample, in_ch.time_step}));
				n_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_samples.size() > 0 && !drain_wait) begin
					sample_t s;
					s = pending_samples.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.rate_sample <= s.rate;
					in_ch.angle_sample <= s.angle;
					in_ch.time_step <= s.dt;
					if (!no_idle && $urandom_range(0, 7) == 0)
						send_gap = $urandom_range(1, 17);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor: checks each estimate against the oldest prediction
	int sink_gap = 0;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_estimates.size() == 0) begin
					$display("%0t: unexpected estimate angle=%0d bias=%0d", $time,
						out_ch.angle_estimate, out_ch.bias_estimate);
					n_errors++;
				end else begin
					estimate_t e;
					e = expected_estimates.pop_front();
					if (out_ch.angle_estimate !== e.angle) begin
						$display("%0t: angle expected %0d actual %0d", $time, e.angle,
							out_ch.angle_estimate);
						n_errors++;
					end
					if (out_ch.bias_estimate !== e.bias) begin
						$display("%0t: bias expected %0d actual %0d", $time, e.bias,
							out_ch.bias_estimate);
						n_errors++;
					end
					n_checked++;
				end
			end
			// long hold-off counted down here, then random idle bursts
			if (hold_cycles > 0) begin
				hold_cycles--;
				out_ch.ready <= 1'b0;
			end else if (sink_gap > 0) begin
				sink_gap--;
				out_ch.ready <= 1'b0;
			end else if (!no_idle && $urandom_range(0, 7) == 0) begin
				sink_gap = $urandom_range(1, 17);
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// watchdog on cycles without any transaction
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready) || hold_cycles > 0)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles > 20000) begin
			$display("%0t: watchdog expired", $time);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic add_sample(logic [31:0] r, logic [31:0] a, logic [23:0] d);
		pending_samples.push_back({r, a, d});
		n_added++;
	endtask

	// random sample: mostly a plausible track, sometimes raw extremes
	task automatic add_random();
		logic [31:0] r, a;
		logic [23:0] d;
		case ($urandom_range(0, 9))
			0: begin
				r = $urandom();
				a = $urandom();
				d = 24'($urandom());
			end
			1: begin
				r = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
				a = $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
				d = $urandom_range(0, 1) ? 24'hffffff : 24'h0;
			end
			default: begin
				r = $signed($urandom_range(0, 2 * 6553600)) - 6553600;
				a = $signed($urandom_range(0, 2 * 5898240)) - 5898240;
				d = 24'($urandom_range(1000, 400000));
			end
		endcase
		add_sample(r, a, d);
	endtask

	// every queued sample has come back as a checked estimate
	task automatic wait_drained();
		while (n_checked < n_added)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [31:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
		// the filter keeps only the low 31 bits, an unused index is dropped
		if (idx == REG_QA) q_angle = value[30:0];
		else if (idx == REG_QB) q_bias = value[30:0];
		else if (idx == REG_RM) q_meas = value[30:0];
	endtask

	task automatic run_random(int count);
		repeat (count) add_random();
		wait_drained();
	endtask

	initial begin
		cfg_ch.valid = 1'b0;
		cfg_ch.index = '0;
		cfg_ch.data = '0;
		filter_reset();
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: field extremes, zero time step, saturating innovation
		add_sample(32'h0, 32'h0, 24'h0);
		add_sample(32'h7fffffff, 32'h7fffffff, 24'hffffff);
		add_sample(32'h80000000, 32'h80000000, 24'hffffff);
		add_sample(32'h7fffffff, 32'h80000000, 24'hffffff);
		add_sample(32'h80000000, 32'h7fffffff, 24'h000001);
		add_sample(32'h00010000, 32'h00050000, 24'h004189);
		add_sample(32'hffff0000, 32'hfffb0000, 24'h800000);
		add_sample(32'h55555555, 32'haaaaaaaa, 24'h555555);
		add_sample(32'haaaaaaaa, 32'h55555555, 24'haaaaaa);
		add_sample(32'h0, 32'h0, 24'h0);
		wait_drained();

		// zero measurement noise, large noises, bad index and wide values
		write_reg(REG_RM, 32'h0);
		write_reg(REG_QA, 32'h7fffffff);
		write_reg(REG_QB, 32'hffffffff);
		write_reg(REG_NONE, 32'h12345678);
		add_sample(32'h00010000, 32'h00020000, 24'h100000);
		add_sample(32'h7fffffff, 32'h80000000, 24'hffffff);
		add_sample(32'h80000000, 32'h7fffffff, 24'hffffff);
		add_sample(32'h12345678, 32'hedcba987, 24'h000010);
		wait_drained();

		write_reg(REG_RM, 32'h1);
		write_reg(REG_QA, 32'h0);
		write_reg(REG_QB, 32'h0);
		run_random(300);

		write_reg(REG_RM, 32'h7fffffff);
		write_reg(REG_QA, 32'd16777);
		write_reg(REG_QB, 32'd168);
		run_random(300);

		// hold the receiver off while the sender keeps offering
		hold_cycles = 2000;
		repeat (30) add_random();
		wait_drained();

		write_reg(REG_RM, 32'd16777216);
		write_reg(REG_QA, $urandom());
		write_reg(REG_QB, $urandom_range(0, 100000));
		run_random(400);

		// sender pauses mid-stream until every estimate is back
		repeat (40) add_random();
		repeat (300) @(posedge clk);
		drain_wait = 1'b1;
		@(posedge clk);
		while (in_ch.valid || n_checked < n_sent)
			@(posedge clk);
		repeat (50) @(posedge clk);
		drain_wait = 1'b0;
		wait_drained();

		write_reg(REG_RM, $urandom_range(1, 32'h7fffffff));
		no_idle = 1'b1;
		run_random(560);

		$display("ran %0d samples through %0d estimate checks", n_sent, n_checked);
		$display("covered noise settings from zero to full scale and saturating inputs");
		if (n_errors == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule
